// ===== rtl/smbb_pkg.sv =====
// ----------------------------------------------------------------------------
// smbb_pkg
// Shared types, constants and the skin classifier for the masked box blur.
// ----------------------------------------------------------------------------
package smbb_pkg;

  localparam int MAX_W     = 1024;
  localparam int MAX_H     = 4096;
  localparam int COL_W     = $clog2(MAX_W);
  localparam int ROW_W     = 13;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int WIN       = 7;
  localparam int HALF      = WIN / 2;
  localparam int LINES     = WIN - 1;
  localparam int SEL_W     = 3;
  localparam int LAG_W     = 12;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int CSUM_W    = 11;
  localparam int TSUM_W    = 14;
  localparam int DIV_K_W   = 15;
  localparam int DIV_K     = 21400;
  localparam int DIV_SH    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // r in [23:16], g in [15:8], b in [7:0]
  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic               res;
    logic               last;
    logic [WIN-1:0]     rmask;
    logic [WIN-1:0]     cmask;
    pixel_t [WIN-1:0]   col;
  } qent_t;

  typedef struct packed {
    logic [7:0] bl;
    logic [7:0] bh;
    logic [7:0] gl;
    logic [7:0] gh;
    logic [7:0] rl;
    logic [7:0] rh;
  } box_t;

  localparam int NBOX = 4;

  localparam box_t BOXES [NBOX] = '{
    '{8'd125, 8'd185, 8'd154, 8'd194, 8'd190, 8'd230},
    '{8'd189, 8'd226, 8'd203, 8'd229, 8'd232, 8'd255},
    '{8'd98,  8'd154, 8'd124, 8'd164, 8'd163, 8'd204},
    '{8'd65,  8'd110, 8'd75,  8'd130, 8'd110, 8'd180}
  };

  function automatic logic skin_test(input pixel_t p);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NBOX; i++) begin
      if (p[7:0] >= BOXES[i].bl && p[7:0] <= BOXES[i].bh &&
          p[15:8] >= BOXES[i].gl && p[15:8] <= BOXES[i].gh &&
          p[23:16] >= BOXES[i].rl && p[23:16] <= BOXES[i].rh) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/smbb_if.sv =====
// ----------------------------------------------------------------------------
// smbb channel interfaces
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface smbb_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  modport source (output valid, req_type, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, req_type, blue_in, green_in, red_in, output ready);
endinterface

interface smbb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       is_skin;
  logic       frame_last;
  modport source (output valid, blue_out, green_out, red_out, is_skin, frame_last,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, is_skin, frame_last,
                  output ready);
endinterface

interface smbb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smbb_pkg::CFG_IDX_W-1:0] addr;
  logic [smbb_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/skin_masked_box_blur.sv =====
// ----------------------------------------------------------------------------
// skin_masked_box_blur
// Skin-selective 7x7 box blur on a BGR raster stream.
//
//   channel  role        handshake      payload
//   pix      item in     valid/ready    req_type, blue_in, green_in, red_in
//   res      result out  valid/ready    blue_out, green_out, red_out, ...
//   cfg      reg write   valid/ready    addr (0 width, 1 height), data
//
// one pixel per clock sustained while results are taken and the queue has room;
// a result passes the line store read, queue, window, column sums, total and divide
// reset is synchronous; frame restarts at reset and on every width or height write
// a stalled result holds the back pipeline; the front keeps accepting until
// the 4-entry queue is full
// ----------------------------------------------------------------------------
module skin_masked_box_blur (
  input  logic       clk,
  input  logic       rst,
  smbb_pix_if.sink   pix,
  smbb_res_if.source res,
  smbb_cfg_if.sink   cfg
);
  import smbb_pkg::*;

  qent_t             ent;
  logic              ent_valid;
  qent_t             head;
  logic              head_valid;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  smbb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg       (cfg),
    .q_count   (q_count),
    .ent       (ent),
    .ent_valid (ent_valid)
  );

  smbb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_ent   (ent),
    .push       (ent_valid),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  smbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res        (res)
  );

endmodule

// ===== rtl/smbb_front.sv =====
// ----------------------------------------------------------------------------
// smbb_front
// Position counters, line stores and classification of each accepted item.
// ----------------------------------------------------------------------------
module smbb_front (
  input  logic                         clk,
  input  logic                         rst,
  smbb_pix_if.sink                     pix,
  smbb_cfg_if.sink                     cfg,
  input  logic [smbb_pkg::QCNT_W-1:0]  q_count,
  output smbb_pkg::qent_t              ent,
  output logic                         ent_valid
);
  import smbb_pkg::*;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [SEL_W-1:0] row_sel;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [LAG_W-1:0] pre_cnt;
  logic [LAG_W-1:0] lag;
  logic             fire;
  logic             cfg_fire;
  logic             has_res;
  logic             last;
  logic             col_wrap;
  pixel_t           px;
  logic [WIN-1:0]   rmask;
  logic [WIN-1:0]   cmask;
  logic             s1_valid;
  logic [SEL_W-1:0] s1_sel;
  pixel_t           s1_px;
  logic             s1_res;
  logic             s1_last;
  logic [WIN-1:0]   s1_rmask;
  logic [WIN-1:0]   s1_cmask;
  pixel_t           rd [LINES];

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid & cfg.ready;
  assign pix.ready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid}) < (QCNT_W+1)'(QDEPTH);
  assign fire      = pix.valid & pix.ready;

  assign lag      = {1'b0, w_eff} + {w_eff, 1'b0} + LAG_W'(HALF);
  assign has_res  = pre_cnt >= lag;
  assign last     = ({1'b0, out_row} + 14'd1 >= {1'b0, h_eff}) &&
                    ({1'b0, out_col} + 11'd1 >= w_eff);
  assign col_wrap = ({1'b0, in_col} + 11'd1) >= w_eff;
  assign px = (!pix.req_type && ({1'b0, in_row} < {1'b0, h_eff})) ?
              {pix.red_in, pix.green_in, pix.blue_in} : '0;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      rmask[k] = ({1'b0, out_row} + 14'(k) >= 14'(HALF)) &&
                 ({1'b0, out_row} + 14'(k) < {1'b0, h_eff} + 14'(HALF));
      cmask[k] = ({2'b0, out_col} + 12'(k) >= 12'(HALF)) &&
                 ({2'b0, out_col} + 12'(k) < {1'b0, w_eff} + 12'(HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= WIDTH_RST;
      h_eff    <= HEIGHT_RST;
      in_col   <= '0;
      in_row   <= '0;
      row_sel  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      pre_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
      if (cfg_fire) begin
        if (cfg.addr == REG_FRAME_WIDTH) begin
          if (cfg.data[WID_W-1:0] == '0) begin
            w_eff <= WID_W'(1);
          end else if (cfg.data[WID_W-1:0] > WID_W'(MAX_W)) begin
            w_eff <= WID_W'(MAX_W);
          end else begin
            w_eff <= cfg.data[WID_W-1:0];
          end
        end else if (cfg.addr == REG_FRAME_HEIGHT) begin
          if (cfg.data == '0) begin
            h_eff <= HGT_W'(1);
          end else if (cfg.data > HGT_W'(MAX_H)) begin
            h_eff <= HGT_W'(MAX_H);
          end else begin
            h_eff <= cfg.data;
          end
        end
        if (cfg.addr == REG_FRAME_WIDTH || cfg.addr == REG_FRAME_HEIGHT) begin
          in_col  <= '0;
          in_row  <= '0;
          row_sel <= '0;
          out_col <= '0;
          out_row <= '0;
          pre_cnt <= '0;
        end
      end else if (fire) begin
        if (has_res && last) begin
          in_col  <= '0;
          in_row  <= '0;
          row_sel <= '0;
          out_col <= '0;
          out_row <= '0;
          pre_cnt <= '0;
        end else begin
          if (col_wrap) begin
            in_col  <= '0;
            in_row  <= in_row + 1'b1;
            row_sel <= (row_sel == SEL_W'(LINES-1)) ? '0 : row_sel + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
          if (!has_res) begin
            pre_cnt <= pre_cnt + 1'b1;
          end else if ({1'b0, out_col} + 11'd1 >= w_eff) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sel   <= row_sel;
      s1_px    <= px;
      s1_res   <= has_res;
      s1_last  <= has_res & last;
      s1_rmask <= rmask;
      s1_cmask <= cmask;
    end
  end

  // line stores, read before write
  for (genvar l = 0; l < LINES; l++) begin : g_line
    pixel_t mem [MAX_W];
    always_ff @(posedge clk) begin
      if (fire) begin
        rd[l] <= mem[in_col];
        if (row_sel == SEL_W'(l)) begin
          mem[in_col] <= px;
        end
      end
    end
  end

  always_comb begin
    logic [SEL_W:0] ix;
    ent.res   = s1_res;
    ent.last  = s1_last;
    ent.rmask = s1_rmask;
    ent.cmask = s1_cmask;
    for (int k = 0; k < LINES; k++) begin
      ix = {1'b0, s1_sel} + (SEL_W+1)'(k);
      if (ix >= (SEL_W+1)'(LINES)) begin
        ix = ix - (SEL_W+1)'(LINES);
      end
      ent.col[k] = rd[ix[SEL_W-1:0]];
    end
    ent.col[WIN-1] = s1_px;
  end

  assign ent_valid = s1_valid;

endmodule

// ===== rtl/smbb_queue.sv =====
// ----------------------------------------------------------------------------
// smbb_queue
// Short queue between the classifying front and the filtering back.
// ----------------------------------------------------------------------------
module smbb_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  smbb_pkg::qent_t              push_ent,
  input  logic                         push,
  input  logic                         pop,
  output smbb_pkg::qent_t              head,
  output logic                         head_valid,
  output logic [smbb_pkg::QCNT_W-1:0]  count
);
  import smbb_pkg::*;

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;

  assign head       = mem[rp];
  assign head_valid = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_ent;
    end
  end

endmodule

// ===== rtl/smbb_back.sv =====
// ----------------------------------------------------------------------------
// smbb_back
// Pixel window, masked 7x7 sums, divide by 49 for skin pixels and the result register.
// ----------------------------------------------------------------------------
module smbb_back (
  input  logic            clk,
  input  logic            rst,
  input  smbb_pkg::qent_t head,
  input  logic            head_valid,
  output logic            pop,
  smbb_res_if.source      res
);
  import smbb_pkg::*;

  pixel_t                     win [WIN][WIN];
  logic                       adv;
  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic                       last1;
  logic                       last2;
  logic                       last3;
  logic [WIN-1:0]             rmask1;
  logic [WIN-1:0]             cmask1;
  logic [WIN-1:0]             cmask2;
  logic [CSUM_W-1:0]          cs_next [3][WIN];
  logic [CSUM_W-1:0]          cs [3][WIN];
  logic [TSUM_W-1:0]          ts_next [3];
  logic [TSUM_W-1:0]          ts [3];
  logic [TSUM_W+DIV_K_W-1:0]  prod [3];
  pixel_t                     ctr2;
  pixel_t                     ctr3;
  logic                       skin2;
  logic                       skin3;

  assign adv = !res.valid || res.ready;
  assign pop = adv & head_valid;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < WIN; j++) begin
        cs_next[c][j] = '0;
        for (int k = 0; k < WIN; k++) begin
          if (rmask1[k]) begin
            cs_next[c][j] = cs_next[c][j] + CSUM_W'(win[k][j][8*c +: 8]);
          end
        end
      end
      ts_next[c] = '0;
      for (int j = 0; j < WIN; j++) begin
        if (cmask2[j]) begin
          ts_next[c] = ts_next[c] + TSUM_W'(cs[c][j]);
        end
      end
      prod[c] = {{DIV_K_W{1'b0}}, ts[c]} * (TSUM_W+DIV_K_W)'(DIV_K);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop & head.res;
      v2        <= v1;
      v3        <= v2;
      res.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN-1; j++) begin
          win[k][j] <= win[k][j+1];
        end
        win[k][WIN-1] <= head.col[k];
      end
    end
    if (adv) begin
      last1  <= head.last;
      rmask1 <= head.rmask;
      cmask1 <= head.cmask;
      cs     <= cs_next;
      cmask2 <= cmask1;
      ctr2   <= win[HALF][HALF];
      skin2  <= skin_test(win[HALF][HALF]);
      last2  <= last1;
      ts     <= ts_next;
      ctr3   <= ctr2;
      skin3  <= skin2;
      last3  <= last2;
      res.is_skin    <= skin3;
      res.frame_last <= last3;
      if (skin3) begin
        res.blue_out  <= prod[0][DIV_SH +: 8];
        res.green_out <= prod[1][DIV_SH +: 8];
        res.red_out   <= prod[2][DIV_SH +: 8];
      end else begin
        res.blue_out  <= ctr3[7:0];
        res.green_out <= ctr3[15:8];
        res.red_out   <= ctr3[23:16];
      end
    end
  end

endmodule

// ===== test/skin_masked_box_blur_test.sv =====
// ----------------------------------------------------------------------------
// skin_masked_box_blur_test
// Streams raster frames of several sizes through the skin-selective box blur
// with random idle gaps on both channels, predicts every result pixel and
// compares it in order against what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skin_masked_box_blur_test;
  import smbb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE = 10;

  typedef struct {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       skin;
    logic       last;
  } blur_px_t;

  // own copy of the skin boxes: b lo/hi, g lo/hi, r lo/hi
  localparam int SKIN_BOX [4][6] = '{
    '{125, 185, 154, 194, 190, 230},
    '{189, 226, 203, 229, 232, 255},
    '{98, 154, 124, 164, 163, 204},
    '{65, 110, 75, 130, 110, 180}
  };

  class blur_scoreboard;
    logic [23:0] line_mem [6][1024];
    logic [23:0] win [7][7];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned width_reg, height_reg;
    blur_px_t    expected_q [$];
    int          errors;
    bit          frame_done;

    function new();
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      width_reg = 640;
      height_reg = 480;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_w();
      return (width_reg < 1) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg < 1) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val[WID_W-1:0];
        restart();
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = val;
        restart();
      end
    endfunction

    function bit is_skin_px(logic [23:0] p);
      bit hit;
      hit = 0;
      for (int i = 0; i < 4; i++)
        if (p[7:0] >= SKIN_BOX[i][0] && p[7:0] <= SKIN_BOX[i][1] &&
            p[15:8] >= SKIN_BOX[i][2] && p[15:8] <= SKIN_BOX[i][3] &&
            p[23:16] >= SKIN_BOX[i][4] && p[23:16] <= SKIN_BOX[i][5])
          hit = 1;
      return hit;
    endfunction

    function void note_pixel(logic rt, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned w, h, lin;
      logic [23:0] px, center;
      logic [23:0] col [7];
      int sb, sg, sr, rr, cc;
      blur_px_t e;
      w = eff_w();
      h = eff_h();
      px = (!rt && in_row < h) ? {r, g, b} : 24'd0;
      if (in_col >= MAX_W) in_col = 0;
      for (int k = 0; k < 6; k++) col[k] = line_mem[(in_row + k) % 6][in_col];
      col[6] = px;
      line_mem[in_row % 6][in_col] = px;
      for (int k = 0; k < 7; k++) begin
        for (int j = 0; j < 6; j++) win[k][j] = win[k][j + 1];
        win[k][6] = col[k];
      end
      lin = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (lin < 3 * w + 3) return;
      sb = 0;
      sg = 0;
      sr = 0;
      for (int k = 0; k < 7; k++) begin
        rr = int'(out_row) + k - 3;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int j = 0; j < 7; j++) begin
          cc = int'(out_col) + j - 3;
          if (cc < 0 || cc >= int'(w)) continue;
          sb += win[k][j][7:0];
          sg += win[k][j][15:8];
          sr += win[k][j][23:16];
        end
      end
      center = win[3][3];
      e.skin = is_skin_px(center);
      if (e.skin) begin
        e.b = 8'(sb / 49);
        e.g = 8'(sg / 49);
        e.r = 8'(sr / 49);
      end else begin
        e.b = center[7:0];
        e.g = center[15:8];
        e.r = center[23:16];
      end
      e.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      expected_q.push_back(e);
      if (e.last) begin
        restart();
        frame_done = 1;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(blur_px_t got);
      blur_px_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result b=%0d g=%0d r=%0d", got.b, got.g, got.r));
        return;
      end
      e = expected_q.pop_front();
      if (got.b !== e.b || got.g !== e.g || got.r !== e.r ||
          got.skin !== e.skin || got.last !== e.last)
        report($sformatf("got b=%0d g=%0d r=%0d skin=%0b last=%0b exp %0d %0d %0d %0b %0b",
                         got.b, got.g, got.r, got.skin, got.last,
                         e.b, e.g, e.r, e.skin, e.last));
    endtask
  endclass

  logic clk;
  logic rst;
  smbb_pix_if pix ();
  smbb_res_if res ();
  smbb_cfg_if cfg ();

  skin_masked_box_blur u_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  blur_scoreboard blur_sb;
  int  hold_cycles;
  bit  tx_busy_free;
  bit  stimulus_done;
  int  pixel_count;

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_pixel();
    int m, bx, lo, hi;
    logic [23:0] p;
    m = $urandom_range(0, 9);
    bx = $urandom_range(0, 3);
    p = 24'($urandom);
    if (m < 4) return p;
    for (int c = 0; c < 3; c++) begin
      lo = SKIN_BOX[bx][2 * c];
      hi = SKIN_BOX[bx][2 * c + 1];
      if (m < 8) begin
        p[8 * c +: 8] = 8'($urandom_range(lo, hi));
      end else begin
        case ($urandom_range(0, 3))
          0: p[8 * c +: 8] = 8'(lo);
          1: p[8 * c +: 8] = 8'(hi);
          2: p[8 * c +: 8] = 8'((lo > 0) ? lo - 1 : lo);
          default: p[8 * c +: 8] = 8'((hi < 255) ? hi + 1 : hi);
        endcase
      end
    end
    return p;
  endfunction

  task automatic send_item(logic rt, logic [23:0] p);
    int gap;
    gap = tx_busy_free ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.req_type = rt;
    pix.blue_in = p[7:0];
    pix.green_in = p[15:8];
    pix.red_in = p[23:16];
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    blur_sb.note_pixel(rt, p[7:0], p[15:8], p[23:16]);
    pixel_count++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    pix.valid = 1'b0;
    while (blur_sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.addr = idx;
    cfg.data = val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    blur_sb.write_reg(idx, val);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // one frame: pixels (some flush ticks inside), then drain with ticks
  task automatic run_frame(int hold_at);
    int n;
    n = blur_sb.eff_w() * blur_sb.eff_h();
    blur_sb.frame_done = 0;
    tx_busy_free = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_cycles = 300;
      send_item($urandom_range(0, 19) == 0, rand_pixel());
    end
    while (!blur_sb.frame_done)
      send_item($urandom_range(0, 4) != 0, rand_pixel());
    go_idle();
  endtask

  initial begin
    blur_sb = new();
    clk = 1'b0;
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.req_type = 1'b0;
    pix.blue_in = '0;
    pix.green_in = '0;
    pix.red_in = '0;
    cfg.valid = 1'b0;
    cfg.addr = REG_FRAME_WIDTH;
    cfg.data = '0;
    hold_cycles = 0;
    tx_busy_free = 0;
    stimulus_done = 0;
    pixel_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry: no result within the first rows of the default frame
    for (int i = 0; i < 40; i++) send_item(1'b0, rand_pixel());
    go_idle();

    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    blur_sb.frame_done = 0;
    send_item(1'b0, 24'hFFFFFF);
    while (!blur_sb.frame_done) send_item(1'b1, 24'h000000);
    go_idle();

    // oversized width: start of a wide frame, still no result
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    for (int i = 0; i < 40; i++) send_item(1'b0, rand_pixel());
    go_idle();

    // oversized height: top of a tall one-pixel-wide frame
    write_reg(REG_SPARE_A, 13'd5);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 20; i++) send_item(1'b0, rand_pixel());
    go_idle();

    write_reg(REG_SPARE_B, 13'h1FFF);
    write_reg(REG_FRAME_WIDTH, 13'd7);
    write_reg(REG_FRAME_HEIGHT, 13'd7);
    run_frame(20);
    run_frame(-1);

    while (pixel_count < 1300) begin
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, 13'($urandom_range(1, 14)));
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(1, 11)));
      run_frame($urandom_range(0, 7) == 0 ? 3 : -1);
    end
    write_reg(REG_FRAME_WIDTH, 13'd1024);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    stimulus_done = 1;
  end

  initial begin
    int n;
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res.ready = 1'b0;
        for (int i = 0; i < hold_cycles; i++) @(negedge clk);
        hold_cycles = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      if (n > 0) begin
        res.ready = 1'b0;
        for (int i = 0; i < n && hold_cycles == 0; i++) @(negedge clk);
      end
      res.ready = 1'b1;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n && hold_cycles == 0; i++) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    blur_px_t got;
    if (!rst && res.valid && res.ready) begin
      got.b = res.blue_out;
      got.g = res.green_out;
      got.r = res.red_out;
      got.skin = res.is_skin;
      got.last = res.frame_last;
      blur_sb.check_result(got);
    end
  end

  initial begin
    wait (stimulus_done);
    repeat (SETTLE) @(posedge clk);
    if (blur_sb.expected_q.size() != 0)
      blur_sb.report($sformatf("%0d results never arrived", blur_sb.expected_q.size()));
    if (blur_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
